FILE: hw/rtl/wlpm_pkg.sv
// Shared constants and mode codes for the windowed latency percentile monitor.
`default_nettype none
package wlpm_pkg;
    localparam int WINDOW_DEPTH_DEF = 2048;
    localparam int TRIM_COUNT_DEF   = 1024;
    localparam int LAT_W            = 32;
    localparam int MODE_W           = 3;
    localparam int PCT_W            = 7;
    localparam int DIVISOR          = 100;

    localparam logic [MODE_W-1:0] MODE_REQ      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REJECT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRIP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SNAPSHOT = 3'd4;

    localparam logic [PCT_W-1:0] PCT_95 = 7'd95;
    localparam logic [PCT_W-1:0] PCT_99 = 7'd99;
endpackage
`default_nettype wire

FILE: hw/rtl/wlpm_window.sv
// Sample ring buffer with trim-on-full append and an indexed, registered read port.
`default_nettype none
module wlpm_window #(
    parameter int DEPTH = wlpm_pkg::WINDOW_DEPTH_DEF,
    parameter int TRIM  = wlpm_pkg::TRIM_COUNT_DEF,
    parameter int PW    = $clog2(DEPTH),
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [wlpm_pkg::LAT_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [PW-1:0]              rd_idx,
    output logic      [wlpm_pkg::LAT_W-1:0] rd_data,
    output logic      [FW-1:0]              fill
);
    localparam int TRIM_EFF = (TRIM > DEPTH) ? DEPTH : TRIM;

    logic [wlpm_pkg::LAT_W-1:0] mem [DEPTH];
    logic [PW-1:0] oldest_reg, oldest_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [PW:0]   trim_sum;
    logic [PW:0]   rd_sum;
    logic [PW-1:0] rd_addr;
    logic          full;

    // Advance pointers; drop the oldest block when full
    always_comb
    begin
        full        = (fill_reg == FW'(DEPTH));
        trim_sum    = {1'b0, oldest_reg} + (PW+1)'(TRIM_EFF);
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        if (wr_en)
        begin
            if (full)
            begin
                if (trim_sum >= (PW+1)'(DEPTH))
                    oldest_next = PW'(trim_sum - (PW+1)'(DEPTH));
                else
                    oldest_next = PW'(trim_sum);
                fill_next = FW'(DEPTH - TRIM_EFF) + FW'(1);
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
            if (wr_ptr_reg == PW'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PW'(1);
        end
    end

    // Map logical index to ring address
    always_comb
    begin
        rd_sum = {1'b0, oldest_reg} + {1'b0, rd_idx};
        if (rd_sum >= (PW+1)'(DEPTH))
            rd_addr = PW'(rd_sum - (PW+1)'(DEPTH));
        else
            rd_addr = PW'(rd_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Sample storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    assign fill = fill_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/windowed_latency_percentile_monitor.sv
// Record words (modes 0-3, ignored modes 5-7) are accepted back to back, one per cycle.
// A snapshot word holds input off from acceptance until the sequencer returns to idle;
// the single radix-select counting unit streams a window once per result bit, and an
// empty window yields zero without a pass. The final output step stretches while the
// previous result is unread. Records do not wait on a held result.
// Reset clears counters and window pointers; samples are not cleared.
`default_nettype none
module windowed_latency_percentile_monitor #(
    parameter int WINDOW_DEPTH = wlpm_pkg::WINDOW_DEPTH_DEF,
    parameter int TRIM_COUNT   = wlpm_pkg::TRIM_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [wlpm_pkg::MODE_W-1:0] mode,
    input  wire logic [wlpm_pkg::LAT_W-1:0]  latency_us,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [wlpm_pkg::LAT_W-1:0]  requests_counted,
    output logic      [wlpm_pkg::LAT_W-1:0]  rejects_total,
    output logic      [wlpm_pkg::LAT_W-1:0]  trips_total,
    output logic      [wlpm_pkg::LAT_W-1:0]  request_p95,
    output logic      [wlpm_pkg::LAT_W-1:0]  request_p99,
    output logic      [wlpm_pkg::LAT_W-1:0]  external_p95
);
    localparam int LW  = wlpm_pkg::LAT_W;
    localparam int PW  = $clog2(WINDOW_DEPTH);
    localparam int FW  = $clog2(WINDOW_DEPTH + 1);
    localparam int PRW = FW + wlpm_pkg::PCT_W;
    // Reciprocal of the divisor, exact for every product below 2**PRW
    localparam int RK  = PRW + wlpm_pkg::PCT_W;
    localparam int RW  = PRW + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RK) + 64'(wlpm_pkg::DIVISOR) - 64'd1) / 64'(wlpm_pkg::DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_BIT   = 3'd4;
    localparam logic [2:0] S_JOB   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] JOB_REQ95 = 2'd0;
    localparam logic [1:0] JOB_REQ99 = 2'd1;
    localparam logic [1:0] JOB_EXT95 = 2'd2;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     job_reg, job_next;
    logic [LW-1:0]  req_cnt_reg, req_cnt_next;
    logic [LW-1:0]  rej_cnt_reg, rej_cnt_next;
    logic [LW-1:0]  trip_cnt_reg, trip_cnt_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [FW-1:0]  k_reg, k_next;
    logic [FW-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]  idx_reg, idx_next;
    logic           issued_all_reg, issued_all_next;
    logic           rd_vld_reg, rd_last_reg;
    logic [LW-1:0]  prefix_reg, prefix_next;
    logic [LW-1:0]  hi_mask_reg, hi_mask_next;
    logic [LW-1:0]  onehot_reg, onehot_next;
    logic [LW-1:0]  res_req95_reg, res_req95_next;
    logic [LW-1:0]  res_req99_reg, res_req99_next;
    logic [LW-1:0]  res_ext95_reg, res_ext95_next;
    logic           out_valid_reg, out_valid_next;
    logic [LW-1:0]  o_req_reg, o_rej_reg, o_trip_reg;
    logic [LW-1:0]  o_p95_reg, o_p99_reg, o_e95_reg;
    logic           load_out;

    logic           in_fire;
    logic           req_wr, ext_wr, issue, last_issue, match;
    logic [FW-1:0]  req_fill, ext_fill, n_sel, n_m1;
    logic [LW-1:0]  req_rd, ext_rd, rd_sel;
    logic [PRW+RW-1:0] recip_prod;
    logic [PRW-1:0] quot_val;
    logic [wlpm_pkg::PCT_W-1:0] pct_sel;
    logic [LW-1:0]  result_val;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign req_wr   = in_fire && (mode == wlpm_pkg::MODE_REQ);
    assign ext_wr   = in_fire && (mode == wlpm_pkg::MODE_EXT);
    assign issue    = (state_reg == S_PASS) && !issued_all_reg;

    wlpm_window #(
        .DEPTH (WINDOW_DEPTH),
        .TRIM  (TRIM_COUNT),
        .PW    (PW),
        .FW    (FW)
    ) u_req_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req_wr),
        .wr_data (latency_us),
        .rd_en   (issue && (job_reg != JOB_EXT95)),
        .rd_idx  (idx_reg),
        .rd_data (req_rd),
        .fill    (req_fill)
    );

    wlpm_window #(
        .DEPTH (WINDOW_DEPTH),
        .TRIM  (TRIM_COUNT),
        .PW    (PW),
        .FW    (FW)
    ) u_ext_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ext_wr),
        .wr_data (latency_us),
        .rd_en   (issue && (job_reg == JOB_EXT95)),
        .rd_idx  (idx_reg),
        .rd_data (ext_rd),
        .fill    (ext_fill)
    );

    // Select the window and percentile of the current job
    always_comb
    begin
        n_sel      = (job_reg == JOB_EXT95) ? ext_fill : req_fill;
        n_m1       = n_sel - FW'(1);
        pct_sel    = (job_reg == JOB_REQ99) ? wlpm_pkg::PCT_99 : wlpm_pkg::PCT_95;
        rd_sel     = (job_reg == JOB_EXT95) ? ext_rd : req_rd;
        last_issue = (idx_reg == PW'(n_m1));
        recip_prod = {{RW{1'b0}}, prod_reg} * {{PRW{1'b0}}, RECIP};
        quot_val   = PRW'(recip_prod >> RK);
        match      = (((rd_sel ^ prefix_reg) & hi_mask_reg) == '0)
                     && ((rd_sel & onehot_reg) == '0);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        req_cnt_next    = req_cnt_reg;
        rej_cnt_next    = rej_cnt_reg;
        trip_cnt_next   = trip_cnt_reg;
        prod_next       = prod_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        issued_all_next = issued_all_reg;
        prefix_next     = prefix_reg;
        hi_mask_next    = hi_mask_reg;
        onehot_next     = onehot_reg;
        res_req95_next  = res_req95_reg;
        res_req99_next  = res_req99_reg;
        res_ext95_next  = res_ext95_reg;
        result_val      = '0;
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode)
                        wlpm_pkg::MODE_REQ:
                        begin
                            if (req_cnt_reg != '1)
                                req_cnt_next = req_cnt_reg + LW'(1);
                        end
                        wlpm_pkg::MODE_REJECT:
                        begin
                            if (rej_cnt_reg != '1)
                                rej_cnt_next = rej_cnt_reg + LW'(1);
                        end
                        wlpm_pkg::MODE_TRIP:
                        begin
                            if (trip_cnt_reg != '1)
                                trip_cnt_next = trip_cnt_reg + LW'(1);
                        end
                        wlpm_pkg::MODE_SNAPSHOT:
                        begin
                            job_next   = JOB_REQ95;
                            state_next = S_SETUP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                // Empty window reads as zero; otherwise form P*(n-1) for the rank
                if (n_sel == '0)
                begin
                    result_val = '0;
                    state_next = S_JOB;
                    case (job_reg)
                        JOB_REQ95: res_req95_next = result_val;
                        JOB_REQ99: res_req99_next = result_val;
                        default:   res_ext95_next = result_val;
                    endcase
                end
                else
                begin
                    prod_next  = PRW'(pct_sel) * PRW'(n_m1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Divide by 100 through the reciprocal and start the first pass
                k_next          = FW'(quot_val);
                prefix_next     = '0;
                hi_mask_next    = '0;
                onehot_next     = {1'b1, {(LW-1){1'b0}}};
                idx_next        = '0;
                cnt_next        = '0;
                issued_all_next = 1'b0;
                state_next      = S_PASS;
            end
            S_PASS:
            begin
                // Stream the window, count samples below the current bit
                if (issue)
                begin
                    if (last_issue)
                        issued_all_next = 1'b1;
                    else
                        idx_next = idx_reg + PW'(1);
                end
                if (rd_vld_reg && match)
                    cnt_next = cnt_reg + FW'(1);
                if (rd_vld_reg && rd_last_reg)
                    state_next = S_BIT;
            end
            S_BIT:
            begin
                // Settle one result bit
                if (k_reg >= cnt_reg)
                begin
                    k_next      = k_reg - cnt_reg;
                    prefix_next = prefix_reg | onehot_reg;
                end
                hi_mask_next = hi_mask_reg | onehot_reg;
                onehot_next  = onehot_reg >> 1;
                if (onehot_reg[0])
                begin
                    result_val = prefix_next;
                    state_next = S_JOB;
                    case (job_reg)
                        JOB_REQ95: res_req95_next = result_val;
                        JOB_REQ99: res_req99_next = result_val;
                        default:   res_ext95_next = result_val;
                    endcase
                end
                else
                begin
                    idx_next        = '0;
                    cnt_next        = '0;
                    issued_all_next = 1'b0;
                    state_next      = S_PASS;
                end
            end
            S_JOB:
            begin
                if (job_reg == JOB_EXT95)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    job_next   = job_reg + 2'd1;
                    state_next = S_SETUP;
                end
            end
            S_OUT:
            begin
                // Hold until the output word is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= JOB_REQ95;
            req_cnt_reg    <= '0;
            rej_cnt_reg    <= '0;
            trip_cnt_reg   <= '0;
            issued_all_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            req_cnt_reg    <= req_cnt_next;
            rej_cnt_reg    <= rej_cnt_next;
            trip_cnt_reg   <= trip_cnt_next;
            issued_all_reg <= issued_all_next;
            rd_vld_reg     <= issue;
            rd_last_reg    <= issue && last_issue;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        k_reg         <= k_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        prefix_reg    <= prefix_next;
        hi_mask_reg   <= hi_mask_next;
        onehot_reg    <= onehot_next;
        res_req95_reg <= res_req95_next;
        res_req99_reg <= res_req99_next;
        res_ext95_reg <= res_ext95_next;
        if (load_out)
        begin
            o_req_reg  <= req_cnt_reg;
            o_rej_reg  <= rej_cnt_reg;
            o_trip_reg <= trip_cnt_reg;
            o_p95_reg  <= res_req95_reg;
            o_p99_reg  <= res_req99_reg;
            o_e95_reg  <= res_ext95_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign requests_counted = o_req_reg;
    assign rejects_total    = o_rej_reg;
    assign trips_total      = o_trip_reg;
    assign request_p95      = o_p95_reg;
    assign request_p99      = o_p99_reg;
    assign external_p95     = o_e95_reg;

`ifndef ASSERT_OFF
    a_snap_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode == wlpm_pkg::MODE_SNAPSHOT)) |=> (state_reg == S_SETUP))
        else $error("snapshot did not start the sequencer");
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> ((n_sel != '0) && (FW'(idx_reg) < n_sel)))
        else $error("window read beyond held samples");
    a_req_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_cnt_reg == '1) |=> (req_cnt_reg == '1))
        else $error("request counter wrapped");
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fill <= FW'(WINDOW_DEPTH)) && (ext_fill <= FW'(WINDOW_DEPTH)))
        else $error("window fill exceeds depth");
`endif
endmodule
`default_nettype wire
